@@ design/abl_pkg.sv @@
package abl_pkg;

	localparam int MODE_W      = 4;
	localparam int DUR_W       = 24;
	localparam int STEP_W      = 16;
	localparam int NUM_STEPS   = 5;
	localparam int CHIME_SEGS  = 5;
	localparam int CHIME_IDX_W = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [MODE_W-1:0]      mode_t;
	typedef logic [STEP_W-1:0]      step_t;
	typedef logic [1:0]             led_mode_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	// command codes
	localparam mode_t MODE_TICK        = 4'd0;
	localparam mode_t MODE_BUZZ_ON     = 4'd1;
	localparam mode_t MODE_BUZZ_OFF    = 4'd2;
	localparam mode_t MODE_PULSE       = 4'd3;
	localparam mode_t MODE_CHIME       = 4'd4;
	localparam mode_t MODE_GREEN_ON    = 4'd5;
	localparam mode_t MODE_GREEN_OFF   = 4'd6;
	localparam mode_t MODE_GREEN_BLINK = 4'd7;
	localparam mode_t MODE_GREEN_TIMED = 4'd8;
	localparam mode_t MODE_RED_ON      = 4'd9;
	localparam mode_t MODE_RED_OFF     = 4'd10;
	localparam mode_t MODE_RED_BLINK   = 4'd11;
	localparam mode_t MODE_CLEAR       = 4'd12;

	// LED pattern codes
	localparam led_mode_t LED_OFF   = 2'd0;
	localparam led_mode_t LED_ON    = 2'd1;
	localparam led_mode_t LED_BLINK = 2'd2;
	localparam led_mode_t LED_TIMED = 2'd3;

	localparam int LED_GREEN = 0;
	localparam int LED_RED   = 1;

	// register map
	localparam cfg_idx_t REG_POLARITY = 3'd0;
	localparam int       REG_STEP0    = 1;

	localparam step_t STEP_RESET [NUM_STEPS] = '{16'd90, 16'd70, 16'd90, 16'd70, 16'd220};

endpackage

@@ design/abl_channels.sv @@
interface abl_cmd_if import abl_pkg::*;;
	logic              valid;
	logic              ready;
	mode_t             mode;
	logic [DUR_W-1:0]  duration;

	modport source (output valid, output mode, output duration, input ready);
	modport sink   (input valid, input mode, input duration, output ready);
endinterface

interface abl_res_if;
	logic valid;
	logic ready;
	logic buzzer_pin;
	logic green_led;
	logic red_led;

	modport source (output valid, output buzzer_pin, output green_led, output red_led,
		input ready);
	modport sink   (input valid, input buzzer_pin, input green_led, input red_led,
		output ready);
endinterface

@@ design/alert_buzzer_led_pattern_controller.sv @@
// Buzzer and two-LED pattern controller. Every command transaction on cmd (a 1 ms tick or a
// buzzer / LED command) produces exactly one result transaction on res carrying the buzzer pin
// and LED levels after that command. Each command is handled combinationally in front of
// the state and result registers, so one command per clock is sustained while res is not
// stalled; the result register is the output stage, and cmd stays ready while res is empty
// or being taken. res.valid rises in the cycle after acceptance. The user must write chime
// segment lengths and buzzer polarity via the cfg port only while idle; it is not enforced.
module alert_buzzer_led_pattern_controller import abl_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	abl_cmd_if.sink               cmd,
	abl_res_if.source             res,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

	typedef logic [TIME_BITS-1:0] time_t;

	// configuration
	logic  polarity_q;
	step_t steps_q [NUM_STEPS];

	// pattern state
	time_t                  time_q, time_d;
	logic                   sound_q, sound_d;
	logic                   pulse_run_q, pulse_run_d;
	time_t                  pulse_end_q, pulse_end_d;
	logic                   chime_run_q, chime_run_d;
	logic [CHIME_IDX_W-1:0] chime_idx_q, chime_idx_d;
	time_t                  chime_end_q, chime_end_d;
	led_mode_t              led_mode_q [2];
	led_mode_t              led_mode_d [2];
	logic [DUR_W-1:0]       led_half_q [2];
	logic [DUR_W-1:0]       led_half_d [2];
	time_t                  led_last_q [2];
	time_t                  led_last_d [2];
	time_t                  led_off_q  [2];
	time_t                  led_off_d  [2];
	logic [1:0]             led_lvl_q, led_lvl_d;

	// result stage
	logic res_valid_q;
	logic res_pin_q;
	logic res_green_q;
	logic res_red_q;

	logic                   accept;
	time_t                  now_inc;
	time_t                  dur_ext;
	logic [CHIME_IDX_W:0]   chime_nxt;
	time_t                  chime_step;
	time_t                  elapsed [2];

	function automatic logic reached(input time_t now_t, input time_t deadline);
		time_t diff;
		diff = now_t - deadline;
		return !diff[TIME_BITS-1];
	endfunction

	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign now_inc    = time_q + 1'b1;
	assign dur_ext    = TIME_BITS'(cmd.duration);
	assign chime_nxt  = {1'b0, chime_idx_q} + 1'b1;
	assign chime_step = (chime_nxt < (CHIME_IDX_W+1)'(NUM_STEPS)) ?
		TIME_BITS'(steps_q[chime_nxt[CHIME_IDX_W-1:0]]) : '0;
	assign elapsed[0] = now_inc - led_last_q[0];
	assign elapsed[1] = now_inc - led_last_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q <= 1'b1;
			for (int i = 0; i < NUM_STEPS; i++) begin
				steps_q[i] <= STEP_RESET[i];
			end
		end else if (cfg_we) begin
			if (cfg_idx == REG_POLARITY) begin
				polarity_q <= cfg_wdata[0];
			end
			for (int i = 0; i < NUM_STEPS; i++) begin
				if (cfg_idx == CFG_IDX_W'(REG_STEP0 + i)) begin
					steps_q[i] <= cfg_wdata[STEP_W-1:0];
				end
			end
		end
	end

	always_comb begin
		time_d      = time_q;
		sound_d     = sound_q;
		pulse_run_d = pulse_run_q;
		pulse_end_d = pulse_end_q;
		chime_run_d = chime_run_q;
		chime_idx_d = chime_idx_q;
		chime_end_d = chime_end_q;
		led_mode_d  = led_mode_q;
		led_half_d  = led_half_q;
		led_last_d  = led_last_q;
		led_off_d   = led_off_q;
		led_lvl_d   = led_lvl_q;

		case (cmd.mode)
			MODE_TICK: begin
				time_d = now_inc;
				if (pulse_run_q && reached(now_inc, pulse_end_q)) begin
					sound_d     = 1'b0;
					pulse_run_d = 1'b0;
				end
				if (chime_run_q && reached(now_inc, chime_end_q)) begin
					chime_idx_d = chime_nxt[CHIME_IDX_W-1:0];
					if (chime_nxt >= (CHIME_IDX_W+1)'(CHIME_SEGS)) begin
						sound_d     = 1'b0;
						chime_run_d = 1'b0;
					end else begin
						// even segments sound
						sound_d     = !chime_nxt[0];
						chime_end_d = now_inc + chime_step;
					end
				end
				for (int i = 0; i < 2; i++) begin
					if (led_mode_q[i] == LED_BLINK) begin
						if (CMP_W'(elapsed[i]) >= CMP_W'(led_half_q[i])) begin
							led_last_d[i] = now_inc;
							led_lvl_d[i]  = !led_lvl_q[i];
						end
					end else if (led_mode_q[i] == LED_TIMED) begin
						if (reached(now_inc, led_off_q[i])) begin
							led_mode_d[i] = LED_OFF;
							led_half_d[i] = '0;
							led_off_d[i]  = '0;
							led_last_d[i] = now_inc;
							led_lvl_d[i]  = 1'b0;
						end
					end
				end
			end
			MODE_BUZZ_ON: begin
				pulse_run_d = 1'b0;
				chime_run_d = 1'b0;
				sound_d     = 1'b1;
			end
			MODE_BUZZ_OFF: begin
				pulse_run_d = 1'b0;
				chime_run_d = 1'b0;
				sound_d     = 1'b0;
			end
			MODE_PULSE: begin
				// drop a zero-length pulse without touching a running chime
				if (cmd.duration != '0) begin
					chime_run_d = 1'b0;
					sound_d     = 1'b1;
					pulse_end_d = time_q + dur_ext;
					pulse_run_d = 1'b1;
				end
			end
			MODE_CHIME: begin
				pulse_run_d = 1'b0;
				chime_idx_d = '0;
				chime_run_d = 1'b1;
				sound_d     = 1'b1;
				chime_end_d = time_q + TIME_BITS'(steps_q[0]);
			end
			MODE_GREEN_ON, MODE_GREEN_OFF, MODE_GREEN_BLINK, MODE_GREEN_TIMED: begin
				led_last_d[LED_GREEN] = time_q;
				led_half_d[LED_GREEN] = '0;
				led_off_d[LED_GREEN]  = '0;
				led_lvl_d[LED_GREEN]  = (cmd.mode != MODE_GREEN_OFF);
				if (cmd.mode == MODE_GREEN_ON) begin
					led_mode_d[LED_GREEN] = LED_ON;
				end else if (cmd.mode == MODE_GREEN_BLINK) begin
					led_mode_d[LED_GREEN] = LED_BLINK;
					led_half_d[LED_GREEN] = cmd.duration;
				end else if (cmd.mode == MODE_GREEN_TIMED) begin
					led_mode_d[LED_GREEN] = LED_TIMED;
					led_off_d[LED_GREEN]  = time_q + dur_ext;
				end else begin
					led_mode_d[LED_GREEN] = LED_OFF;
				end
			end
			MODE_RED_ON, MODE_RED_OFF, MODE_RED_BLINK: begin
				led_last_d[LED_RED] = time_q;
				led_half_d[LED_RED] = '0;
				led_off_d[LED_RED]  = '0;
				led_lvl_d[LED_RED]  = (cmd.mode != MODE_RED_OFF);
				if (cmd.mode == MODE_RED_ON) begin
					led_mode_d[LED_RED] = LED_ON;
				end else if (cmd.mode == MODE_RED_BLINK) begin
					led_mode_d[LED_RED] = LED_BLINK;
					led_half_d[LED_RED] = cmd.duration;
				end else begin
					led_mode_d[LED_RED] = LED_OFF;
				end
			end
			MODE_CLEAR: begin
				pulse_run_d = 1'b0;
				chime_run_d = 1'b0;
				sound_d     = 1'b0;
				for (int i = 0; i < 2; i++) begin
					led_mode_d[i] = LED_OFF;
					led_half_d[i] = '0;
					led_off_d[i]  = '0;
					led_last_d[i] = time_q;
					led_lvl_d[i]  = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			sound_q     <= 1'b0;
			pulse_run_q <= 1'b0;
			pulse_end_q <= '0;
			chime_run_q <= 1'b0;
			chime_idx_q <= '0;
			chime_end_q <= '0;
			led_lvl_q   <= '0;
			for (int i = 0; i < 2; i++) begin
				led_mode_q[i] <= LED_OFF;
				led_half_q[i] <= '0;
				led_last_q[i] <= '0;
				led_off_q[i]  <= '0;
			end
		end else if (accept) begin
			time_q      <= time_d;
			sound_q     <= sound_d;
			pulse_run_q <= pulse_run_d;
			pulse_end_q <= pulse_end_d;
			chime_run_q <= chime_run_d;
			chime_idx_q <= chime_idx_d;
			chime_end_q <= chime_end_d;
			led_mode_q  <= led_mode_d;
			led_half_q  <= led_half_d;
			led_last_q  <= led_last_d;
			led_off_q   <= led_off_d;
			led_lvl_q   <= led_lvl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			res_pin_q   <= !(sound_d ^ polarity_q);
			res_green_q <= led_lvl_d[LED_GREEN];
			res_red_q   <= led_lvl_d[LED_RED];
		end
	end

	assign res.valid      = res_valid_q;
	assign res.buzzer_pin = res_pin_q;
	assign res.green_led  = res_green_q;
	assign res.red_led    = res_red_q;

endmodule

@@ design/abl_checker.sv @@
module abl_checker import abl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input mode_t            cmd_mode,
	input logic             res_valid,
	input logic             res_ready,
	input logic             res_buzzer_pin,
	input logic             res_green_led,
	input logic             res_red_led
);

	logic cmd_xfer;

	assign cmd_xfer = cmd_valid && cmd_ready;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_buzzer_pin)
			&& $stable(res_green_led) && $stable(res_red_led))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command not taken while result stage empty");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> res_valid)
		else $error("no result after command transaction");

	a_clear_dark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && cmd_mode == MODE_CLEAR |=> !res_green_led && !res_red_led)
		else $error("LEDs lit after clear");

	a_green_off: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && cmd_mode == MODE_GREEN_OFF |=> !res_green_led)
		else $error("green LED lit after green off");

endmodule

bind alert_buzzer_led_pattern_controller abl_checker u_abl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_mode       (cmd.mode),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_buzzer_pin (res.buzzer_pin),
	.res_green_led  (res.green_led),
	.res_red_led    (res.red_led)
);

@@ dv/alert_buzzer_led_pattern_controller_tb.sv @@
`timescale 1ns / 1ps

module alert_buzzer_led_pattern_controller_tb import abl_pkg::*;;

	localparam int TIME_BITS = 32;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 160;
	localparam mode_t MODE_SPARE_FIRST = MODE_CLEAR + 4'd1;
	localparam mode_t MODE_LAST_CODE = '1;
	localparam cfg_idx_t REG_SPARE_FIRST = cfg_idx_t'(REG_STEP0 + NUM_STEPS);
	localparam cfg_idx_t REG_LAST = '1;
	localparam logic [DUR_W-1:0] DUR_MAX = '1;

	typedef logic [TIME_BITS-1:0] time_word_t;
	typedef logic [DUR_W-1:0] dur_t;

	typedef struct packed {
		logic buzzer_pin;
		logic green_led;
		logic red_led;
	} levels_t;

	typedef struct {
		mode_t   m;
		dur_t    d;
		bit      typed;
		levels_t lv;
	} drill_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	abl_cmd_if cmd_ch();
	abl_res_if res_ch();

	alert_buzzer_led_pattern_controller #(.TIME_BITS(TIME_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// shadow copy of the controller
	logic polarity;
	step_t chime_len [8];
	time_word_t now_ms;
	logic buzzing, pulse_on, chime_on;
	time_word_t pulse_due, chime_due;
	logic [CHIME_IDX_W-1:0] chime_pos;
	led_mode_t led_pat [2];
	dur_t led_half [2];
	time_word_t led_toggled [2];
	time_word_t led_due [2];
	logic led_lit [2];

	levels_t expected_levels [$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int take_stall_pct = 0;

	drill_row_t drills [25] = '{
		'{MODE_TICK,        '0,        1'b1, '{1'b0, 1'b0, 1'b0}},
		'{MODE_BUZZ_ON,     '0,        1'b1, '{1'b1, 1'b0, 1'b0}},
		'{MODE_BUZZ_OFF,    DUR_MAX,   1'b1, '{1'b0, 1'b0, 1'b0}},
		'{MODE_GREEN_ON,    '0,        1'b1, '{1'b0, 1'b1, 1'b0}},
		'{MODE_RED_ON,      '0,        1'b1, '{1'b0, 1'b1, 1'b1}},
		'{MODE_GREEN_OFF,   '0,        1'b1, '{1'b0, 1'b0, 1'b1}},
		'{MODE_RED_OFF,     '0,        1'b1, '{1'b0, 1'b0, 1'b0}},
		'{MODE_PULSE,       '0,        1'b1, '{1'b0, 1'b0, 1'b0}},
		'{MODE_PULSE,       24'd2,     1'b1, '{1'b1, 1'b0, 1'b0}},
		'{MODE_TICK,        '0,        1'b0, '0},
		'{MODE_TICK,        '0,        1'b0, '0},
		'{MODE_TICK,        '0,        1'b0, '0},
		'{MODE_SPARE_FIRST, DUR_MAX,   1'b0, '0},
		'{MODE_LAST_CODE,   '0,        1'b0, '0},
		'{MODE_CHIME,       DUR_MAX,   1'b1, '{1'b1, 1'b0, 1'b0}},
		'{MODE_PULSE,       '0,        1'b0, '0},
		'{MODE_GREEN_BLINK, '0,        1'b1, '{1'b1, 1'b1, 1'b0}},
		'{MODE_TICK,        '0,        1'b0, '0},
		'{MODE_TICK,        '0,        1'b0, '0},
		'{MODE_RED_BLINK,   DUR_MAX,   1'b0, '0},
		'{MODE_GREEN_TIMED, 24'd1,     1'b0, '0},
		'{MODE_TICK,        '0,        1'b0, '0},
		'{MODE_PULSE,       DUR_MAX,   1'b0, '0},
		'{MODE_CLEAR,       '0,        1'b1, '{1'b0, 1'b0, 1'b0}},
		'{MODE_GREEN_TIMED, DUR_MAX,   1'b0, '0}
	};

	task automatic reset_shadow();
		polarity = 1'b1;
		foreach (chime_len[i]) chime_len[i] = '0;
		for (int i = 0; i < NUM_STEPS; i++) chime_len[i] = STEP_RESET[i];
		now_ms = '0;
		buzzing = 1'b0;
		pulse_on = 1'b0;
		chime_on = 1'b0;
		pulse_due = '0;
		chime_due = '0;
		chime_pos = '0;
		for (int i = 0; i < 2; i++) begin
			led_pat[i] = LED_OFF;
			led_half[i] = '0;
			led_toggled[i] = '0;
			led_due[i] = '0;
			led_lit[i] = 1'b0;
		end
	endtask

	// deadline counts as reached when the wrapped difference is non-negative
	function automatic logic deadline_hit(time_word_t now, time_word_t deadline);
		time_word_t diff;
		diff = now - deadline;
		return !diff[TIME_BITS-1];
	endfunction

	task automatic set_led_shadow(int i, led_mode_t pat, logic lit, dur_t half,
		time_word_t due);
		led_pat[i] = pat;
		led_half[i] = half;
		led_due[i] = due;
		led_toggled[i] = now_ms;
		led_lit[i] = lit;
	endtask

	task automatic tick_shadow();
		int next;
		time_word_t elapsed;
		now_ms = now_ms + 1'b1;
		if (pulse_on && deadline_hit(now_ms, pulse_due)) begin
			buzzing = 1'b0;
			pulse_on = 1'b0;
		end
		if (chime_on && deadline_hit(now_ms, chime_due)) begin
			next = int'(chime_pos) + 1;
			chime_pos = next[CHIME_IDX_W-1:0];
			if (next >= CHIME_SEGS) begin
				buzzing = 1'b0;
				chime_on = 1'b0;
			end else begin
				buzzing = !next[0];
				chime_due = now_ms + time_word_t'(chime_len[next]);
			end
		end
		for (int i = 0; i < 2; i++) begin
			elapsed = now_ms - led_toggled[i];
			if (led_pat[i] == LED_BLINK) begin
				if (elapsed >= time_word_t'(led_half[i])) begin
					led_toggled[i] = now_ms;
					led_lit[i] = !led_lit[i];
				end
			end else if (led_pat[i] == LED_TIMED) begin
				if (deadline_hit(now_ms, led_due[i]))
					set_led_shadow(i, LED_OFF, 1'b0, '0, '0);
			end
		end
	endtask

	task automatic predict_levels(mode_t m, dur_t d, output levels_t lv);
		case (m)
			MODE_TICK: tick_shadow();
			MODE_BUZZ_ON, MODE_BUZZ_OFF: begin
				pulse_on = 1'b0;
				chime_on = 1'b0;
				buzzing = (m == MODE_BUZZ_ON);
			end
			MODE_PULSE: begin
				// a zero-length pulse leaves everything alone
				if (d != '0) begin
					chime_on = 1'b0;
					buzzing = 1'b1;
					pulse_due = now_ms + time_word_t'(d);
					pulse_on = 1'b1;
				end
			end
			MODE_CHIME: begin
				pulse_on = 1'b0;
				chime_pos = '0;
				chime_on = 1'b1;
				buzzing = 1'b1;
				chime_due = now_ms + time_word_t'(chime_len[0]);
			end
			MODE_GREEN_ON:    set_led_shadow(LED_GREEN, LED_ON, 1'b1, '0, '0);
			MODE_GREEN_OFF:   set_led_shadow(LED_GREEN, LED_OFF, 1'b0, '0, '0);
			MODE_GREEN_BLINK: set_led_shadow(LED_GREEN, LED_BLINK, 1'b1, d, '0);
			MODE_GREEN_TIMED:
				set_led_shadow(LED_GREEN, LED_TIMED, 1'b1, '0, now_ms + time_word_t'(d));
			MODE_RED_ON:      set_led_shadow(LED_RED, LED_ON, 1'b1, '0, '0);
			MODE_RED_OFF:     set_led_shadow(LED_RED, LED_OFF, 1'b0, '0, '0);
			MODE_RED_BLINK:   set_led_shadow(LED_RED, LED_BLINK, 1'b1, d, '0);
			MODE_CLEAR: begin
				pulse_on = 1'b0;
				chime_on = 1'b0;
				buzzing = 1'b0;
				set_led_shadow(LED_GREEN, LED_OFF, 1'b0, '0, '0);
				set_led_shadow(LED_RED, LED_OFF, 1'b0, '0, '0);
			end
			default: ;
		endcase
		lv.buzzer_pin = buzzing ? polarity : !polarity;
		lv.green_led = led_lit[LED_GREEN];
		lv.red_led = led_lit[LED_RED];
	endtask

	// present one command, hold it until the transaction happens
	task automatic send_cmd(mode_t m, dur_t d, bit typed = 1'b0, levels_t typed_lv = '0);
		levels_t lv;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid = 1'b0;
			cmd_ch.mode = mode_t'($urandom);
			cmd_ch.duration = dur_t'($urandom);
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.mode = m;
		cmd_ch.duration = d;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_levels(m, d, lv);
		expected_levels.push_back(typed ? typed_lv : lv);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		cmd_ch.valid = 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_POLARITY)
			polarity = val[0];
		else if (int'(idx) < REG_STEP0 + NUM_STEPS)
			chime_len[int'(idx) - REG_STEP0] = val;
	endtask

	function automatic step_t pick_step(int ph);
		case (ph)
			1: return '0;
			3: return '1;
			default: begin
				if ($urandom_range(0, 15) == 0) return step_t'($urandom);
				return step_t'($urandom_range(0, 6));
			end
		endcase
	endfunction

	function automatic dur_t pick_duration();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return DUR_MAX;
			2: return dur_t'($urandom);
			default: return dur_t'($urandom_range(1, 12));
		endcase
	endfunction

	always @(negedge clk)
		res_ch.ready <= ($urandom_range(0, 99) >= take_stall_pct);

	always @(posedge clk) begin
		levels_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_levels.size() == 0) begin
				$error("result transaction with no command outstanding");
				fail_count++;
			end else begin
				want = expected_levels.pop_front();
				if (res_ch.buzzer_pin !== want.buzzer_pin) begin
					$error("buzzer_pin mismatch: expected %0b, got %0b",
						want.buzzer_pin, res_ch.buzzer_pin);
					fail_count++;
				end
				if (res_ch.green_led !== want.green_led) begin
					$error("green_led mismatch: expected %0b, got %0b",
						want.green_led, res_ch.green_led);
					fail_count++;
				end
				if (res_ch.red_led !== want.red_led) begin
					$error("red_led mismatch: expected %0b, got %0b",
						want.red_led, res_ch.red_led);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("alert_buzzer_led_pattern_controller_tb NOT OK");
		$finish;
	end

	initial begin
		int sent;
		int burst;
		mode_t m;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_TICK;
		cmd_ch.duration = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_POLARITY;
		cfg_wdata = '0;
		reset_shadow();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (drills[i])
			send_cmd(drills[i].m, drills[i].d, drills[i].typed, drills[i].lv);
		wait_idle();

		for (int ph = 1; ph <= PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
				1: begin send_idle_pct = 74; take_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  take_stall_pct = 74; end
				default: begin send_idle_pct = 11; take_stall_pct = 11; end
			endcase
			write_reg(REG_POLARITY, {(CFG_DATA_W-1)'($urandom), ph[0]});
			for (int s = 0; s < NUM_STEPS; s++)
				write_reg(cfg_idx_t'(REG_STEP0 + s), pick_step(ph));
			// indexes past the last register must have no effect
			write_reg(REG_SPARE_FIRST, CFG_DATA_W'($urandom));
			write_reg(REG_LAST, CFG_DATA_W'($urandom));

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) < 2) begin
					// run of ticks lets chimes, pulses and blinks play out
					burst = $urandom_range(1, 20);
					repeat (burst) send_cmd(MODE_TICK, dur_t'($urandom));
					sent += burst;
				end else begin
					if ($urandom_range(0, 1) == 0)
						m = MODE_TICK;
					else
						m = mode_t'($urandom_range(MODE_BUZZ_ON, MODE_LAST_CODE));
					send_cmd(m, pick_duration());
					sent++;
				end
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("alert_buzzer_led_pattern_controller_tb OK");
		else
			$display("alert_buzzer_led_pattern_controller_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
design/abl_pkg.sv
design/abl_channels.sv
design/alert_buzzer_led_pattern_controller.sv
design/abl_checker.sv
dv/alert_buzzer_led_pattern_controller_tb.sv
